// ----- hw/rtl/trpv_pkg.sv -----
// Shared types, register indexes and saturation helpers for the three-axis
// ramp-then-proportional velocity core. No dependencies.

package trpv_pkg;

   localparam int AXES = 3;
   localparam int AXIS_YAW = 2;

   // Fixed field widths
   localparam int Q_W     = 32;  // signed Q16.16 position and speed
   localparam int ERR_W   = 33;  // exact difference of two Q16.16 values
   localparam int FRAC_W  = 16;  // unsigned Q0.16 ramp fraction
   localparam int WIDE_W  = 34;  // ramp and clamp arithmetic
   localparam int PROD_W  = 64;  // error magnitude times gain
   localparam int CSR_W   = 64;
   localparam int CSR_IDX_W = 3;
   localparam int TOL_YAW_W = 31;
   localparam int FRAC_ALL_W = 48;

   typedef logic signed [Q_W-1:0]    q16_type;
   typedef logic signed [ERR_W-1:0]  err_type;
   typedef logic signed [WIDE_W-1:0] wide_type;
   typedef logic        [Q_W-1:0]    umag_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_TOL_XY   = 3'd0,
      REG_TOL_YAW  = 3'd1,
      REG_ACCEL    = 3'd2,
      REG_FRACS    = 3'd3,
      REG_MAX_SPD  = 3'd4,
      REG_MIN_SPD  = 3'd5,
      REG_GAINS    = 3'd6
   } csr_index_type;

   // Input word kinds
   localparam logic OP_GOAL = 1'b0;
   localparam logic OP_TICK = 1'b1;

   // Saturate a 34-bit signed value to 32 bits signed
   function automatic q16_type sat_wide(input wide_type v);
      q16_type r;
      if (v > $signed(34'sh0_7FFF_FFFF)) begin
         r = 32'sh7FFF_FFFF;
      end else if (v < $signed(-34'sh0_8000_0000)) begin
         r = 32'sh8000_0000;
      end else begin
         r = v[Q_W-1:0];
      end
      return r;
   endfunction

   // Saturate a 33-bit signed error to 32 bits signed
   function automatic q16_type sat_err(input err_type v);
      return sat_wide(WIDE_W'(v));
   endfunction

   // Magnitude of an exact error; it never exceeds 2^32 - 1
   function automatic umag_type mag_err(input err_type v);
      err_type n;
      n = -v;
      return v[ERR_W-1] ? n[Q_W-1:0] : v[Q_W-1:0];
   endfunction

endpackage

// ----- hw/rtl/three_axis_ramp_then_p_velocity_core.sv -----
// Top level of the three-axis ramp-then-proportional velocity core.
// Depends on trpv_pkg for types, register indexes and saturation helpers.
//
// Three-axis (x, y, yaw) goal-seeking velocity controller in signed Q16.16.
// A goal word (req_tuser = 0) stores the target and latches each axis's ramp
// threshold; it returns nothing. A tick word (req_tuser = 1) carries the
// measured position and returns exactly one word with the commanded
// velocities and the reached flag. Every word passes through an input
// register and is resolved in one pass into the result register, so the core
// takes one word per clock while no tick word waits on a held result. A word's
// result is offered from the result register until it is taken. The gain
// multiply of each axis, with its saturation and clamps, sets the length of
// that pass. While a result waits, goal words still pass and the input
// register takes one more tick word, which holds until the result is taken.
// Configuration may be written only while no word is in flight.

module three_axis_ramp_then_p_velocity_core (
   input  logic                             clock,
   input  logic                             reset,
   // Input words
   input  logic                             req_tvalid,
   output logic                             req_tready,
   input  logic [3*trpv_pkg::Q_W-1:0]       req_tdata,  // value_x, value_y, value_yaw
   input  logic                             req_tuser,  // op
   // Result words
   output logic                             rsp_tvalid,
   input  logic                             rsp_tready,
   output logic [3*trpv_pkg::Q_W-1:0]       rsp_tdata,  // speed_x, speed_y, speed_yaw
   output logic                             rsp_tuser,  // reached
   // Configuration writes
   input  logic                             csr_we,
   input  logic [trpv_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [trpv_pkg::CSR_W-1:0]       csr_wdata
);

   localparam int AXES  = trpv_pkg::AXES;
   localparam int Q_W   = trpv_pkg::Q_W;
   localparam int ERR_W = trpv_pkg::ERR_W;
   localparam int WIDE_W = trpv_pkg::WIDE_W;
   localparam int FRAC_W = trpv_pkg::FRAC_W;
   localparam int PROD_W = trpv_pkg::PROD_W;

   // Configuration registers
   logic [trpv_pkg::CSR_W-1:0]      tol_xy_ff;
   logic [trpv_pkg::TOL_YAW_W-1:0]  tol_yaw_ff;
   logic [trpv_pkg::CSR_W-1:0]      accel_ff;
   logic [trpv_pkg::FRAC_ALL_W-1:0] fracs_ff;
   logic [trpv_pkg::CSR_W-1:0]      max_spd_ff;
   logic [trpv_pkg::CSR_W-1:0]      min_spd_ff;
   logic [trpv_pkg::CSR_W-1:0]      gains_ff;

   // Input register
   logic                    in_valid_ff;
   logic                    in_op_ff;
   trpv_pkg::q16_type       in_pos_ff [AXES];

   // Controller state
   trpv_pkg::q16_type       goal_ff   [AXES];
   trpv_pkg::q16_type       start_ff  [AXES];
   trpv_pkg::umag_type      thresh_ff [AXES];
   trpv_pkg::q16_type       cmd_ff    [AXES];
   trpv_pkg::umag_type      peak_ff   [AXES];
   trpv_pkg::q16_type       goal_in   [AXES];
   trpv_pkg::q16_type       start_in  [AXES];
   trpv_pkg::umag_type      thresh_in [AXES];
   trpv_pkg::q16_type       cmd_in    [AXES];
   trpv_pkg::umag_type      peak_in   [AXES];

   // Result register
   logic                    rsp_valid_ff;
   logic                    rsp_valid_in;
   logic [3*Q_W-1:0]        rsp_data_ff;
   logic                    rsp_reached_ff;

   // Handshake
   logic                    advance;
   logic                    is_tick;
   logic                    req_accept;

   // Per-axis working values
   trpv_pkg::umag_type      ax_tol   [AXES];
   trpv_pkg::umag_type      ax_acc   [AXES];
   logic [FRAC_W-1:0]       ax_frac  [AXES];
   trpv_pkg::umag_type      ax_max   [AXES];
   trpv_pkg::umag_type      ax_min   [AXES];
   trpv_pkg::umag_type      ax_gain  [AXES];
   trpv_pkg::err_type       err      [AXES];
   trpv_pkg::umag_type      err_mag  [AXES];
   trpv_pkg::q16_type       err_sat  [AXES];
   trpv_pkg::umag_type      esat_mag [AXES];
   trpv_pkg::err_type       gdiff    [AXES];
   logic [Q_W+FRAC_W:0]     thr_prod [AXES];
   logic [PROD_W-1:0]       p_prod   [AXES];
   logic [PROD_W-Q_W+Q_W/2-1:0] p_val [AXES];
   trpv_pkg::q16_type       p_signed [AXES];
   trpv_pkg::wide_type      ramp_sum [AXES];
   trpv_pkg::wide_type      ramp_clp [AXES];
   trpv_pkg::q16_type       ramp_v   [AXES];
   trpv_pkg::umag_type      ramp_mag [AXES];
   trpv_pkg::umag_type      lim      [AXES];
   trpv_pkg::wide_type      pv_w     [AXES];
   trpv_pkg::wide_type      lim_w    [AXES];
   trpv_pkg::wide_type      min_w    [AXES];
   trpv_pkg::wide_type      max_w    [AXES];
   trpv_pkg::wide_type      pclp     [AXES];
   logic                    all_zero;
   logic                    stop_hit;

   // Move a word from the input register into state and the result register
   assign is_tick    = (in_op_ff == trpv_pkg::OP_TICK);
   assign advance    = in_valid_ff && (!is_tick || !rsp_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign req_accept = req_tvalid && req_tready;

   assign rsp_valid_in = (advance && is_tick) || (rsp_valid_ff && !rsp_tready);

   // Per-axis arithmetic, one independent lane per axis
   always_comb begin
      all_zero = 1'b1;
      stop_hit = 1'b1;
      for (int a = 0; a < AXES; a++) begin
         // Axis fields of the configuration
         if (a == 0) begin
            ax_tol[a] = tol_xy_ff[Q_W-1:0];
         end else if (a == 1) begin
            ax_tol[a] = tol_xy_ff[2*Q_W-1:Q_W];
         end else begin
            ax_tol[a] = Q_W'(tol_yaw_ff);
         end
         if (a == trpv_pkg::AXIS_YAW) begin
            ax_acc[a]  = accel_ff[2*Q_W-1:Q_W];
            ax_max[a]  = max_spd_ff[2*Q_W-1:Q_W];
            ax_min[a]  = min_spd_ff[2*Q_W-1:Q_W];
            ax_gain[a] = gains_ff[2*Q_W-1:Q_W];
         end else begin
            ax_acc[a]  = accel_ff[Q_W-1:0];
            ax_max[a]  = max_spd_ff[Q_W-1:0];
            ax_min[a]  = min_spd_ff[Q_W-1:0];
            ax_gain[a] = gains_ff[Q_W-1:0];
         end
         ax_frac[a] = fracs_ff[FRAC_W*a +: FRAC_W];

         // Ramp threshold for a new goal
         gdiff[a]    = ERR_W'(in_pos_ff[a]) - ERR_W'(start_ff[a]);
         thr_prod[a] = (Q_W+FRAC_W+1)'(trpv_pkg::mag_err(gdiff[a]))
                     * (Q_W+FRAC_W+1)'((FRAC_W+1)'(1 << FRAC_W) - (FRAC_W+1)'(ax_frac[a]));

         // Tracking error and stop test
         err[a]     = ERR_W'(goal_ff[a]) - ERR_W'(in_pos_ff[a]);
         err_mag[a] = trpv_pkg::mag_err(err[a]);
         if (err[a] != '0) begin
            all_zero = 1'b0;
         end
         if (!(err_mag[a] < ax_tol[a])) begin
            stop_hit = 1'b0;
         end

         // Ramp path: step, clamp to the maximum, saturate
         if (err[a] > 0) begin
            ramp_sum[a] = WIDE_W'(cmd_ff[a]) + $signed(WIDE_W'(ax_acc[a]));
         end else begin
            ramp_sum[a] = WIDE_W'(cmd_ff[a]) - $signed(WIDE_W'(ax_acc[a]));
         end
         max_w[a] = $signed(WIDE_W'(ax_max[a]));
         if (ramp_sum[a] > max_w[a]) begin
            ramp_clp[a] = max_w[a];
         end else if (ramp_sum[a] < -max_w[a]) begin
            ramp_clp[a] = -max_w[a];
         end else begin
            ramp_clp[a] = ramp_sum[a];
         end
         ramp_v[a]   = trpv_pkg::sat_wide(ramp_clp[a]);
         ramp_mag[a] = trpv_pkg::mag_err(ERR_W'(ramp_v[a]));

         // Proportional path: saturated error times gain
         err_sat[a]  = trpv_pkg::sat_err(err[a]);
         esat_mag[a] = trpv_pkg::mag_err(ERR_W'(err_sat[a]));
         p_prod[a]   = PROD_W'(esat_mag[a]) * PROD_W'(ax_gain[a]);
         p_val[a]    = p_prod[a][PROD_W-1:Q_W/2];
         if (err_sat[a][Q_W-1]) begin
            if (p_val[a] > (PROD_W-Q_W/2)'(33'h0_8000_0000)) begin
               p_signed[a] = 32'sh8000_0000;
            end else begin
               p_signed[a] = -$signed(p_val[a][Q_W-1:0]);
            end
         end else begin
            if (p_val[a] > (PROD_W-Q_W/2)'(32'h7FFF_FFFF)) begin
               p_signed[a] = 32'sh7FFF_FFFF;
            end else begin
               p_signed[a] = p_val[a][Q_W-1:0];
            end
         end

         // Clamp to the smaller of maximum and peak, then enforce the minimum
         lim[a]   = (ax_max[a] < peak_ff[a]) ? ax_max[a] : peak_ff[a];
         lim_w[a] = $signed(WIDE_W'(lim[a]));
         min_w[a] = $signed(WIDE_W'(ax_min[a]));
         pv_w[a]  = WIDE_W'(p_signed[a]);
         priority if (pv_w[a] > lim_w[a]) begin
            pclp[a] = lim_w[a];
         end else if (pv_w[a] < -lim_w[a]) begin
            pclp[a] = -lim_w[a];
         end else if (pv_w[a] > 0 && pv_w[a] < min_w[a]) begin
            pclp[a] = min_w[a];
         end else if (pv_w[a] < 0 && pv_w[a] > -min_w[a]) begin
            pclp[a] = -min_w[a];
         end else begin
            pclp[a] = pv_w[a];
         end
      end
      stop_hit = stop_hit && !all_zero;
   end

   // Next state of the controller
   always_comb begin
      for (int a = 0; a < AXES; a++) begin
         goal_in[a]   = goal_ff[a];
         start_in[a]  = start_ff[a];
         thresh_in[a] = thresh_ff[a];
         cmd_in[a]    = cmd_ff[a];
         peak_in[a]   = peak_ff[a];
         if (advance) begin
            if (!is_tick) begin
               // New goal: store target and latch threshold
               goal_in[a]   = in_pos_ff[a];
               thresh_in[a] = thr_prod[a][Q_W+FRAC_W-1:FRAC_W];
            end else if (stop_hit) begin
               // Reached: hold position as the next start
               start_in[a] = in_pos_ff[a];
               cmd_in[a]   = '0;
            end else if (err_mag[a] > ax_tol[a] && err_mag[a] > thresh_ff[a]) begin
               cmd_in[a] = ramp_v[a];
               if (ramp_mag[a] > peak_ff[a]) begin
                  peak_in[a] = ramp_mag[a];
               end
            end else if (err_mag[a] > ax_tol[a]) begin
               cmd_in[a] = trpv_pkg::sat_wide(pclp[a]);
            end else begin
               cmd_in[a] = '0;
            end
         end
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         tol_xy_ff  <= '0;
         tol_yaw_ff <= '0;
         accel_ff   <= '0;
         fracs_ff   <= '0;
         max_spd_ff <= '0;
         min_spd_ff <= '0;
         gains_ff   <= '0;
      end else if (csr_we) begin
         unique case (trpv_pkg::csr_index_type'(csr_index))
            trpv_pkg::REG_TOL_XY:  tol_xy_ff  <= csr_wdata;
            trpv_pkg::REG_TOL_YAW: tol_yaw_ff <= csr_wdata[trpv_pkg::TOL_YAW_W-1:0];
            trpv_pkg::REG_ACCEL:   accel_ff   <= csr_wdata;
            trpv_pkg::REG_FRACS:   fracs_ff   <= csr_wdata[trpv_pkg::FRAC_ALL_W-1:0];
            trpv_pkg::REG_MAX_SPD: max_spd_ff <= csr_wdata;
            trpv_pkg::REG_MIN_SPD: min_spd_ff <= csr_wdata;
            trpv_pkg::REG_GAINS:   gains_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Input register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   // Input register: payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_op_ff <= req_tuser;
         for (int a = 0; a < AXES; a++) begin
            in_pos_ff[a] <= req_tdata[Q_W*a +: Q_W];
         end
      end
   end

   // Controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int a = 0; a < AXES; a++) begin
            goal_ff[a]   <= '0;
            start_ff[a]  <= '0;
            thresh_ff[a] <= '0;
            cmd_ff[a]    <= '0;
            peak_ff[a]   <= '0;
         end
      end else begin
         for (int a = 0; a < AXES; a++) begin
            goal_ff[a]   <= goal_in[a];
            start_ff[a]  <= start_in[a];
            thresh_ff[a] <= thresh_in[a];
            cmd_ff[a]    <= cmd_in[a];
            peak_ff[a]   <= peak_in[a];
         end
      end
   end

   // Result register: control
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Result register: payload, loaded when a tick word resolves
   always_ff @(posedge clock) begin
      if (advance && is_tick) begin
         rsp_reached_ff <= stop_hit;
         for (int a = 0; a < AXES; a++) begin
            rsp_data_ff[Q_W*a +: Q_W] <= cmd_in[a];
         end
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_reached_ff;

endmodule

// ----- sim/three_axis_ramp_then_p_velocity_core_test.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for the three-axis ramp-then-proportional velocity core.
// Drives goal and tick words, predicts each commanded-speed word and compares it.
// Depends on trpv_pkg and three_axis_ramp_then_p_velocity_core only.

module three_axis_ramp_then_p_velocity_core_test;
   import trpv_pkg::*;

   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 3'd7;  // unmapped index, must be ignored
   localparam longint SPEED_HI = 64'sd2147483647;
   localparam longint SPEED_LO = -64'sd2147483648;
   localparam int PHASES = 6;
   localparam int WORDS_PER_PHASE = 225;

   typedef struct {
      logic        op;
      logic [95:0] data;
      bit          hold;   // wait for all results before sending this word
   } ctl_word_type;

   typedef struct {
      logic [95:0] speeds;
      logic        reached;
   } command_type;

   logic clock = 1'b0;
   logic reset;
   logic req_tvalid;
   logic req_tready;
   logic [95:0] req_tdata;    // value_x, value_y, value_yaw
   logic req_tuser;           // op
   logic rsp_tvalid;
   logic rsp_tready;
   logic [95:0] rsp_tdata;    // speed_x, speed_y, speed_yaw
   logic rsp_tuser;           // reached
   logic csr_we;
   logic [CSR_IDX_W-1:0] csr_index;
   logic [CSR_W-1:0] csr_wdata;

   // Shadow copies of the configuration registers
   logic [63:0] tol_xy_reg;
   logic [30:0] tol_yaw_reg;
   logic [63:0] accel_reg;
   logic [47:0] fracs_reg;
   logic [63:0] max_reg;
   logic [63:0] min_reg;
   logic [63:0] gains_reg;

   // Controller state as the core should hold it
   longint goal_pos [3];
   longint start_pos [3];
   longint unsigned ramp_thr [3];
   longint speed_cmd [3];
   longint unsigned peak_mag [3];

   ctl_word_type pending_words [$];
   command_type  commands_due [$];
   ctl_word_type cur_word;
   command_type  seen_due;
   int tx_idle_pct;
   int rx_idle_pct;
   int mismatches;
   string axis_name [3] = '{"speed_x", "speed_y", "speed_yaw"};

   three_axis_ramp_then_p_velocity_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #4 clock = ~clock;

   function automatic longint sat_q(input longint v);
      if (v > SPEED_HI) return SPEED_HI;
      if (v < SPEED_LO) return SPEED_LO;
      return v;
   endfunction

   function automatic longint unsigned magn(input longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Planar axes share the low half of a register, yaw takes the high half
   function automatic longint unsigned axis_part(input logic [63:0] r, input int a);
      return (a < 2) ? 64'(r[31:0]) : 64'(r[63:32]);
   endfunction

   function automatic longint unsigned tol_of(input int a);
      case (a)
         0: return 64'(tol_xy_reg[31:0]);
         1: return 64'(tol_xy_reg[63:32]);
         default: return 64'(tol_yaw_reg);
      endcase
   endfunction

   // Advance the controller by one accepted word; queue the command a tick returns
   function automatic void step_controller(input ctl_word_type w);
      longint pos [3];
      longint err [3];
      longint unsigned frac, m, tol, p;
      longint mx, acc, v, e, lim, mn;
      bit all_zero, stop;
      command_type c;
      all_zero = 1'b1;
      stop = 1'b1;
      c.speeds = '0;
      for (int a = 0; a < AXES; a++) pos[a] = longint'($signed(w.data[32*a +: 32]));

      // Goal: store target, latch ramp threshold from the distance to cover
      if (w.op == OP_GOAL) begin
         for (int a = 0; a < AXES; a++) begin
            frac = 64'(fracs_reg[16*a +: 16]);
            goal_pos[a] = pos[a];
            ramp_thr[a] = (magn(goal_pos[a] - start_pos[a]) * (64'd65536 - frac)) >> 16;
         end
         return;
      end

      for (int a = 0; a < AXES; a++) begin
         err[a] = goal_pos[a] - pos[a];
         if (err[a] != 0) all_zero = 1'b0;
         if (!(magn(err[a]) < tol_of(a))) stop = 1'b0;
      end

      if (!all_zero && stop) begin
         // Arrived: stop and take this position as the next start
         for (int a = 0; a < AXES; a++) begin
            start_pos[a] = pos[a];
            speed_cmd[a] = 0;
         end
         c.reached = 1'b1;
      end else begin
         for (int a = 0; a < AXES; a++) begin
            m = magn(err[a]);
            tol = tol_of(a);
            mx = $signed(axis_part(max_reg, a));
            if (m > tol && m > ramp_thr[a]) begin
               // Far away: ramp by the step, clamp, track the peak magnitude
               acc = $signed(axis_part(accel_reg, a));
               v = speed_cmd[a] + ((err[a] > 0) ? acc : -acc);
               if (v > mx) v = mx;
               else if (v < -mx) v = -mx;
               v = sat_q(v);
               speed_cmd[a] = v;
               if (magn(v) > peak_mag[a]) peak_mag[a] = magn(v);
            end else if (m > tol) begin
               // Close in: proportional, limited by max and peak, floored by min
               e = sat_q(err[a]);
               p = (magn(e) * axis_part(gains_reg, a)) >> 16;
               lim = $signed(peak_mag[a]);
               mn = $signed(axis_part(min_reg, a));
               v = (e < 0) ? -$signed(p) : $signed(p);
               v = sat_q(v);
               if (mx < lim) lim = mx;
               if (v > lim) v = lim;
               else if (v < -lim) v = -lim;
               else if (v > 0 && v < mn) v = mn;
               else if (v < 0 && v > -mn) v = -mn;
               speed_cmd[a] = sat_q(v);
            end else begin
               speed_cmd[a] = 0;
            end
         end
         c.reached = 1'b0;
      end

      for (int a = 0; a < AXES; a++) c.speeds[32*a +: 32] = speed_cmd[a][31:0];
      commands_due.push_back(c);
   endfunction

   // Sender: present queued words, predict each one as it is accepted
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         req_tuser <= 1'b0;
         req_tdata <= '0;
      end else begin
         if (req_tvalid && req_tready) begin
            step_controller(cur_word);
         end
         if (!req_tvalid || req_tready) begin
            if (pending_words.size() != 0 && $urandom_range(99) >= tx_idle_pct &&
                !(pending_words[0].hold && commands_due.size() != 0)) begin
               cur_word = pending_words.pop_front();
               req_tvalid <= 1'b1;
               req_tuser <= cur_word.op;
               req_tdata <= cur_word.data;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Receiver: stall at random, compare each accepted word with the oldest command due
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (commands_due.size() == 0) begin
               $display("%0t: unexpected word: speeds %h reached %b",
                        $time, rsp_tdata, rsp_tuser);
               mismatches++;
            end else begin
               seen_due = commands_due.pop_front();
               for (int a = 0; a < AXES; a++) begin
                  if (rsp_tdata[32*a +: 32] !== seen_due.speeds[32*a +: 32]) begin
                     $display("%0t: %s expected %h actual %h", $time, axis_name[a],
                              seen_due.speeds[32*a +: 32], rsp_tdata[32*a +: 32]);
                     mismatches++;
                  end
               end
               if (rsp_tuser !== seen_due.reached) begin
                  $display("%0t: reached expected %b actual %b",
                           $time, seen_due.reached, rsp_tuser);
                  mismatches++;
               end
            end
         end
         rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [63:0] val);
      @(posedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_we <= 1'b0;
      case (idx)
         REG_TOL_XY:  tol_xy_reg = val;
         REG_TOL_YAW: tol_yaw_reg = val[30:0];
         REG_ACCEL:   accel_reg = val;
         REG_FRACS:   fracs_reg = val[47:0];
         REG_MAX_SPD: max_reg = val;
         REG_MIN_SPD: min_reg = val;
         REG_GAINS:   gains_reg = val;
         default: ;
      endcase
   endtask

   task automatic queue_word(input logic op, input logic [31:0] x, input logic [31:0] y,
                             input logic [31:0] yaw, input bit hold);
      ctl_word_type w;
      w.op = op;
      w.data = {yaw, y, x};
      w.hold = hold;
      pending_words.push_back(w);
   endtask

   // Hold until every word is in and every command is out, then let goal words settle
   task automatic wait_idle();
      while (pending_words.size() != 0 || req_tvalid || commands_due.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // One goal followed by ticks that close in on it and end near the goal
   task automatic queue_approach(input int ticks);
      longint goal [3];
      longint gap [3];
      logic [31:0] p [3];
      longint span, off;
      longint unsigned t;
      for (int a = 0; a < AXES; a++) begin
         if ($urandom_range(3) == 0) goal[a] = longint'($signed($urandom()));
         else goal[a] = longint'($urandom_range(1 << 24)) - (1 << 23);
      end
      span = 64'd1 << $urandom_range(31, 6);
      for (int a = 0; a < AXES; a++) begin
         gap[a] = longint'($urandom_range(32'(span)));
         if ($urandom_range(1) == 1) gap[a] = -gap[a];
      end
      queue_word(OP_GOAL, 32'(goal[0]), 32'(goal[1]), 32'(goal[2]), $urandom_range(29) == 0);
      for (int k = 1; k < ticks; k++) begin
         for (int a = 0; a < AXES; a++)
            p[a] = 32'(goal[a] - gap[a] * (ticks - k) / ticks
                       + longint'($urandom_range(31)) - 16);
         queue_word(OP_TICK, p[0], p[1], p[2], 1'b0);
      end
      // Final tick lands inside tolerance, now and then right on it
      for (int a = 0; a < AXES; a++) begin
         t = tol_of(a);
         if (t == 0) off = 0;
         else if ($urandom_range(9) == 0) off = $signed(t);
         else off = longint'($urandom_range(32'(t - 1)));
         if ($urandom_range(1) == 1) off = -off;
         p[a] = 32'(goal[a] - off);
      end
      queue_word(OP_TICK, p[0], p[1], p[2], 1'b0);
   endtask

   initial begin
      #3_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   initial begin
      int placed, ticks;
      logic [63:0] cfg [7];
      reset = 1'b1;
      csr_we = 1'b0;
      csr_index = '0;
      csr_wdata = '0;
      mismatches = 0;
      tx_idle_pct = 29;
      rx_idle_pct = 88;
      tol_xy_reg = '0; tol_yaw_reg = '0; accel_reg = '0; fracs_reg = '0;
      max_reg = '0; min_reg = '0; gains_reg = '0;
      for (int a = 0; a < AXES; a++) begin
         goal_pos[a] = 0; start_pos[a] = 0; ramp_thr[a] = 0;
         speed_cmd[a] = 0; peak_mag[a] = 0;
      end
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // Directed: hand-picked settings
      write_reg(REG_TOL_XY,  {32'h0000_1000, 32'h0000_1000});
      write_reg(REG_TOL_YAW, 64'h0000_0800);
      write_reg(REG_ACCEL,   {32'h0000_2000, 32'h0000_4000});
      write_reg(REG_FRACS,   {16'h8000, 16'h4000, 16'h4000});
      write_reg(REG_MAX_SPD, {32'h0001_0000, 32'h0002_0000});
      write_reg(REG_MIN_SPD, {32'h0000_0200, 32'h0000_0400});
      write_reg(REG_GAINS,   {32'h0000_8000, 32'h0001_0000});
      write_reg(REG_SPARE,   64'hA5A5_5A5A_F00D_0FF0);

      // Tick with every error zero: not reached
      queue_word(OP_TICK, 32'h0, 32'h0, 32'h0, 1'b0);
      // Far goal: ramp, then proportional near the end
      queue_word(OP_GOAL, 32'h0010_0000, 32'hFFF0_0000, 32'h0004_0000, 1'b0);
      repeat (3) queue_word(OP_TICK, 32'h0, 32'h0, 32'h0, 1'b0);
      queue_word(OP_TICK, 32'h000C_0000, 32'hFFF4_0000, 32'h0003_0000, 1'b0);
      // x error equal to tolerance: not reached, x goes to zero
      queue_word(OP_TICK, 32'h000F_F000, 32'hFFF0_0800, 32'h0004_0100, 1'b0);
      // All inside tolerance, sent only after the pipe drains
      queue_word(OP_TICK, 32'h000F_F800, 32'hFFF0_0400, 32'h0004_0100, 1'b1);
      // Extremes: errors span the full 33-bit range and saturate
      queue_word(OP_GOAL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_word(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_word(OP_TICK, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_word(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_word(OP_GOAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0);
      queue_word(OP_TICK, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0);
      queue_word(OP_TICK, 32'h8000_0010, 32'h7FFF_FFF0, 32'h8000_0004, 1'b0);
      wait_idle();

      // Minimum speed beyond the signed range, tiny gains
      write_reg(REG_MIN_SPD, 64'hFFFF_FFFF_FFFF_FFFF);
      write_reg(REG_GAINS,   {32'h0000_0100, 32'h0000_0100});
      queue_word(OP_GOAL, 32'h0002_0000, 32'hFFFE_0000, 32'h0001_0000, 1'b0);
      queue_word(OP_TICK, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
      queue_word(OP_TICK, 32'h0003_8000, 32'hFFFC_0000, 32'h0001_8000, 1'b0);
      queue_word(OP_TICK, 32'h0001_F800, 32'hFFFE_0400, 32'h0001_0100, 1'b0);
      wait_idle();

      // Random phases, each with its own settings
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph < 2) begin
            tx_idle_pct = 29; rx_idle_pct = 88;
         end else if (ph < 4) begin
            tx_idle_pct = 88; rx_idle_pct = 29;
         end else begin
            tx_idle_pct = 0; rx_idle_pct = 0;
         end
         for (int r = 0; r < 7; r++) begin
            if (ph == 0) cfg[r] = '1;
            else if (ph == 1) cfg[r] = '0;
            else if ($urandom_range(7) == 0) cfg[r] = {$urandom(), $urandom()};
            else begin
               case (r)
                  0: cfg[r] = {32'($urandom_range(1 << 16)), 32'($urandom_range(1 << 16))};
                  1: cfg[r] = 64'($urandom_range(1 << 15));
                  2: cfg[r] = {32'($urandom_range(1 << 17)), 32'($urandom_range(1 << 18))};
                  3: cfg[r] = {16'($urandom()), 16'($urandom()), 16'($urandom())};
                  4: cfg[r] = {32'($urandom_range(1 << 20)), 32'($urandom_range(1 << 21))};
                  5: cfg[r] = {32'($urandom_range(1 << 12)), 32'($urandom_range(1 << 12))};
                  default: cfg[r] = {32'($urandom_range(1 << 19)), 32'($urandom_range(1 << 19))};
               endcase
            end
         end
         write_reg(REG_TOL_XY,  cfg[0]);
         write_reg(REG_TOL_YAW, cfg[1]);
         write_reg(REG_ACCEL,   cfg[2]);
         write_reg(REG_FRACS,   cfg[3]);
         write_reg(REG_MAX_SPD, cfg[4]);
         write_reg(REG_MIN_SPD, cfg[5]);
         write_reg(REG_GAINS,   cfg[6]);
         write_reg(REG_SPARE,   {$urandom(), $urandom()});

         // Mostly goal-then-approach runs, the rest raw noise
         placed = 0;
         while (placed < WORDS_PER_PHASE) begin
            if ($urandom_range(99) < 15) begin
               queue_word(1'($urandom_range(1)), $urandom(), $urandom(), $urandom(),
                          $urandom_range(39) == 0);
               placed++;
            end else begin
               ticks = $urandom_range(14, 2);
               queue_approach(ticks);
               placed += ticks + 1;
            end
         end
         wait_idle();
      end

      repeat (8) @(posedge clock);
      if (mismatches == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
